// File: hdl/ficu_pkg.sv
// Package with the shared format and action codes and the value width of the converter.
package ficu_pkg;

   localparam int ValueWidth = 32;

   localparam logic [1:0] FMT_S16 = 2'd0;
   localparam logic [1:0] FMT_S8  = 2'd1;
   localparam logic [1:0] FMT_U16 = 2'd2;
   localparam logic [1:0] FMT_U8  = 2'd3;

   localparam logic ACT_F2I = 1'b0;
   localparam logic ACT_I2F = 1'b1;

endpackage

// File: hdl/ficu_f2i.sv
// Float to saturated integer conversion, combinational.
module ficu_f2i (
   input  logic [31:0] bits_in,
   input  logic [1:0]  fmt_in,
   output logic [31:0] int_out
);

   logic [7:0]  expo;
   logic        neg;
   logic        is_nan;
   logic [23:0] sig;
   logic [16:0] mag;
   logic        big;
   logic [16:0] hi_mag;
   logic [16:0] lo_mag;
   logic        is_signed;
   logic [16:0] clamped;
   logic [31:0] ext;

   always_comb begin
      expo      = bits_in[30:23];
      neg       = bits_in[31];
      is_nan    = (expo == 8'hFF) && (bits_in[22:0] != 23'd0);
      sig       = {1'b1, bits_in[22:0]};
      is_signed = (fmt_in == ficu_pkg::FMT_S16) || (fmt_in == ficu_pkg::FMT_S8);
      // Any magnitude of 2^16 or more saturates every format.
      big = (expo >= 8'd143);
      mag = 17'd0;
      if (expo >= 8'd127 && !big) begin
         mag = 17'(sig >> (5'd23 - 5'(expo - 8'd127)));
      end
      case (fmt_in)
         ficu_pkg::FMT_S16: begin hi_mag = 17'd32767; lo_mag = 17'd32768; end
         ficu_pkg::FMT_S8:  begin hi_mag = 17'd127;   lo_mag = 17'd128;   end
         ficu_pkg::FMT_U16: begin hi_mag = 17'd65535; lo_mag = 17'd0;     end
         default:           begin hi_mag = 17'd255;   lo_mag = 17'd0;     end
      endcase
      if (neg) begin
         clamped = (big || mag > lo_mag) ? lo_mag : mag;
         ext = 32'd0 - {15'd0, clamped};
      end else begin
         clamped = (big || mag > hi_mag) ? hi_mag : mag;
         ext = {15'd0, clamped};
      end
      if (is_nan || (!is_signed && neg)) begin
         ext = 32'd0;
      end
      int_out = ext;
   end

endmodule

// File: hdl/ficu_i2f.sv
// Integer to float conversion, exact for all four formats, combinational.
module ficu_i2f (
   input  logic [31:0] raw_in,
   input  logic [1:0]  fmt_in,
   output logic [31:0] float_out
);

   logic [16:0] mag;
   logic        sign;
   logic [4:0]  p;
   logic [16:0] norm;

   always_comb begin
      sign = 1'b0;
      case (fmt_in)
         ficu_pkg::FMT_S16: begin
            sign = raw_in[15];
            mag  = sign ? 17'h10000 - {1'b0, raw_in[15:0]} : {1'b0, raw_in[15:0]};
         end
         ficu_pkg::FMT_S8: begin
            sign = raw_in[7];
            mag  = sign ? 17'h100 - {9'd0, raw_in[7:0]} : {9'd0, raw_in[7:0]};
         end
         ficu_pkg::FMT_U16: mag = {1'b0, raw_in[15:0]};
         default:           mag = {9'd0, raw_in[7:0]};
      endcase
      // Priority encode the leading one.
      p = 5'd0;
      for (int i = 0; i < 17; i++) begin
         if (mag[i]) begin
            p = 5'(i);
         end
      end
      norm = mag << (5'd16 - p);
      if (mag == 17'd0) begin
         float_out = 32'd0;
      end else begin
         float_out = {sign, 8'(8'd127 + {3'd0, p}), norm[15:0], 7'd0};
      end
   end

endmodule

// File: hdl/float_int_convert_unit_top.sv
// Top level of the float and integer converter with its input and result registers.
//
// The converter takes one item per clock cycle: an item is accepted when start is high
// and busy is low, and busy is always low because the block never stalls. The item is
// registered in the input registers, converted by a single pass of combinational logic,
// and registered again in the result register; it appears on the rsp_ ports with
// rsp_valid high for exactly one cycle. The receiver cannot hold results off, so
// results stream out at the same rate as items arrive. The float to integer path and
// the leading-one search of the integer to float path set the cycle time.
module float_int_convert_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [1:0]  req_int_format,
   input  logic [31:0] req_value_in,
   output logic        rsp_valid,
   output logic [31:0] rsp_value_out
);

   logic        in_valid_ff;
   logic        in_action_ff;
   logic [1:0]  in_fmt_ff;
   logic [31:0] in_value_ff;
   logic        out_valid_ff;
   logic [31:0] out_value_ff;
   logic [31:0] f2i_result;
   logic [31:0] i2f_result;
   logic [31:0] out_value_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= start;
         out_valid_ff <= in_valid_ff;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      in_action_ff <= req_action;
      in_fmt_ff    <= req_int_format;
      in_value_ff  <= req_value_in;
      out_value_ff <= out_value_in;
   end

   ficu_f2i u_f2i (
      .bits_in (in_value_ff),
      .fmt_in  (in_fmt_ff),
      .int_out (f2i_result)
   );

   ficu_i2f u_i2f (
      .raw_in    (in_value_ff),
      .fmt_in    (in_fmt_ff),
      .float_out (i2f_result)
   );

   assign out_value_in  = (in_action_ff == ficu_pkg::ACT_I2F) ? i2f_result : f2i_result;
   assign rsp_valid     = out_valid_ff;
   assign rsp_value_out = out_value_ff;

`ifndef SYNTH
   a_pipe: assert property (@(posedge clock) disable iff (reset)
      start |-> ##2 rsp_valid) else $error("accepted item produced no result");
   a_noinv: assert property (@(posedge clock) disable iff (reset)
      !$past(start, 2) && !$past(reset, 2) |-> !rsp_valid)
      else $error("result without an item");
   a_u8: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(in_action_ff) == ficu_pkg::ACT_F2I
      && $past(in_fmt_ff) == ficu_pkg::FMT_U8 |-> rsp_value_out[31:8] == 24'd0)
      else $error("unsigned 8 result out of range");
`endif

endmodule

// File: sim/tb.sv
// Testbench for the float and integer converter: random and corner items checked in order.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Conversion predictor and queue of pending results.
   class conv_scoreboard;
      logic [31:0] pending_q[$];
      int          n_fail;

      function new();
         n_fail = 0;
      endfunction

      // Float to integer, truncating toward zero and clamping to the format.
      static function logic [31:0] float_to_fixed(logic [31:0] bits, logic [1:0] fmt);
         logic [7:0]  expo;
         logic [63:0] sig;
         longint      mag;
         longint      v;
         longint      lo;
         longint      hi;
         int          e;
         expo = bits[30:23];
         if (expo == 8'hFF && bits[22:0] != 0) return 32'd0;
         sig = {40'd0, 1'b1, bits[22:0]};
         e = int'(expo) - 127;
         if (expo == 8'hFF || e >= 31) mag = 64'd1 << 31;
         else if (e < 0) mag = 0;
         else if (e <= 23) mag = sig >> (23 - e);
         else mag = sig << (e - 23);
         v = bits[31] ? -mag : mag;
         case (fmt)
            ficu_pkg::FMT_S16: begin lo = -32768; hi = 32767; end
            ficu_pkg::FMT_S8:  begin lo = -128;   hi = 127;   end
            ficu_pkg::FMT_U16: begin lo = 0;      hi = 65535; end
            default:           begin lo = 0;      hi = 255;   end
         endcase
         if (v > hi) v = hi;
         if (v < lo) v = lo;
         return v[31:0];
      endfunction

      // Integer to float; every source fits the significand, so it is exact.
      static function logic [31:0] fixed_to_float(logic [31:0] raw, logic [1:0] fmt);
         logic [31:0] mag;
         logic        sgn;
         int          p;
         sgn = 1'b0;
         case (fmt)
            ficu_pkg::FMT_S16: begin
               mag = {16'd0, raw[15:0]};
               if (raw[15]) begin sgn = 1'b1; mag = 32'h10000 - mag; end
            end
            ficu_pkg::FMT_S8: begin
               mag = {24'd0, raw[7:0]};
               if (raw[7]) begin sgn = 1'b1; mag = 32'h100 - mag; end
            end
            ficu_pkg::FMT_U16: mag = {16'd0, raw[15:0]};
            default:           mag = {24'd0, raw[7:0]};
         endcase
         if (mag == 0) return 32'd0;
         p = 0;
         while (p < 31 && (mag >> (p + 1)) != 0) p++;
         return {sgn, 8'(127 + p), 23'((mag << (23 - p)) & 32'h7FFFFF)};
      endfunction

      function void note_item(logic act, logic [1:0] fmt, logic [31:0] val);
         pending_q.push_back(act == ficu_pkg::ACT_I2F ? fixed_to_float(val, fmt)
                                                      : float_to_fixed(val, fmt));
      endfunction

      function void check_result(logic [31:0] got);
         logic [31:0] want;
         if (pending_q.size() == 0) begin
            $error("value_out: unexpected result, expected none, actual %h", got);
            n_fail++;
            return;
         end
         want = pending_q.pop_front();
         if (got !== want) begin
            $error("value_out: expected %h, actual %h", want, got);
            n_fail++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_action;
   logic [1:0]  req_int_format;
   logic [31:0] req_value_in;
   logic        rsp_valid;
   logic [31:0] rsp_value_out;

   conv_scoreboard conv_sb;

   float_int_convert_unit_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_int_format (req_int_format),
      .req_value_in   (req_value_in),
      .rsp_valid      (rsp_valid),
      .rsp_value_out  (rsp_value_out)
   );

   // 4 ns clock period.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Results are sampled at the rising edge; the receiver never stalls.
   always @(posedge clock) begin
      if (!reset && rsp_valid) conv_sb.check_result(rsp_value_out);
   end

   // Presents one item from a falling edge and holds it until it is accepted.
   // The item is noted at the accepting rising edge, so start stays high
   // between back-to-back items without being lowered in between.
   task automatic send_item(logic act, logic [1:0] fmt, logic [31:0] val);
      start          <= 1'b1;
      req_action     <= act;
      req_int_format <= fmt;
      req_value_in   <= val;
      do @(posedge clock); while (busy);
      conv_sb.note_item(act, fmt, val);
      @(negedge clock);
   endtask

   // Drops start for a random gap: mostly none or short, now and then long.
   task automatic idle_gap();
      int n;
      n = $urandom_range(0, 99);
      if (n < 50) n = 0;
      else if (n < 92) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 40);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Random float pattern that leans toward the interesting exponents:
   // around the integer ranges, tiny values, huge values and all-ones.
   function automatic logic [31:0] rand_float();
      logic [7:0] expo;
      int         pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       expo = 8'hFF;
         1:       expo = 8'h00;
         2:       expo = 8'($urandom_range(0, 126));
         3:       expo = 8'($urandom_range(158, 254));
         default: expo = 8'($urandom_range(127, 158));
      endcase
      return {1'($urandom), expo, 23'($urandom)};
   endfunction

   initial begin
      logic [31:0] dir_vals[$];
      int          k;

      conv_sb        = new();
      reset          = 1'b1;
      start          = 1'b0;
      req_action     = ficu_pkg::ACT_F2I;
      req_int_format = ficu_pkg::FMT_S16;
      req_value_in   = 32'd0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed floats: both zeros, denormal, NaNs, infinities, the largest
      // finite value, exact range edges and values just beyond them.
      dir_vals = '{32'h00000000, 32'h80000000, 32'h00000001, 32'h7FC00000,
                   32'hFF800001, 32'h7F800000, 32'hFF800000, 32'h7F7FFFFF,
                   32'h46FFFE00, 32'hC7000000, 32'h477FFF00, 32'h47800000,
                   32'hBF7FFFFF, 32'h3FFFFFFF, 32'h4F000000, 32'hCF000000};
      foreach (dir_vals[i]) send_item(ficu_pkg::ACT_F2I, 2'(i % 4), dir_vals[i]);
      // Directed integers: zero, extremes of each format, junk in upper bits.
      send_item(ficu_pkg::ACT_I2F, ficu_pkg::FMT_S16, 32'hFFFF8000);
      send_item(ficu_pkg::ACT_I2F, ficu_pkg::FMT_S16, 32'h00007FFF);
      send_item(ficu_pkg::ACT_I2F, ficu_pkg::FMT_S8,  32'hABCDEF80);
      send_item(ficu_pkg::ACT_I2F, ficu_pkg::FMT_S8,  32'h0000007F);
      send_item(ficu_pkg::ACT_I2F, ficu_pkg::FMT_U16, 32'hFFFFFFFF);
      send_item(ficu_pkg::ACT_I2F, ficu_pkg::FMT_U8,  32'h123456FF);
      send_item(ficu_pkg::ACT_I2F, ficu_pkg::FMT_U8,  32'hFFFFFF00);
      send_item(ficu_pkg::ACT_I2F, ficu_pkg::FMT_S16, 32'h00000001);

      // Random part.
      for (k = 0; k < 1750; k++) begin
         if ($urandom_range(0, 1)) send_item(ficu_pkg::ACT_F2I, 2'($urandom), rand_float());
         else send_item(ficu_pkg::ACT_I2F, 2'($urandom), $urandom());
         idle_gap();
      end
      start <= 1'b0;

      // Drain: wait until every pending result has come out.
      k = 0;
      while (conv_sb.pending_q.size() != 0 && k < 1000) begin
         @(posedge clock);
         k++;
      end
      repeat (5) @(posedge clock);
      if (conv_sb.n_fail == 0 && conv_sb.pending_q.size() == 0) begin
         $display("** float_int_convert_unit_top: PASSED **");
      end else begin
         if (conv_sb.pending_q.size() != 0)
            $error("value_out: expected %0d more results, actual none",
                   conv_sb.pending_q.size());
         $display("** float_int_convert_unit_top: FAILED **");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #2ms;
      $display("** float_int_convert_unit_top: FAILED **");
      $finish;
   end

endmodule

// File: float_int_convert_unit_top.f
hdl/ficu_pkg.sv
hdl/ficu_f2i.sv
hdl/ficu_i2f.sv
hdl/float_int_convert_unit_top.sv
sim/tb.sv
